### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the port-level checker file
// Each macro expects clk and rst_n to be visible where it is used.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted
`define CPMM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpmm check failed: same-cycle implication");

// Next-cycle implication, quiet while reset is asserted
`define CPMM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpmm check failed: next-cycle implication");

`endif

### rtl/cpmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpmm_pkg
// Types and constants of the CAN payload mask matcher.
// ---------------------------------------------------------------------------
package cpmm_pkg;

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned VALUE_W   = 29;
  localparam int unsigned TIME_W    = 63;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [VALUE_W-1:0]   value_t;
  typedef logic [TIME_W-1:0]    stamp_t;
  typedef logic [PAYLOAD_W-1:0] payload_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Symbol kinds; anything else counts as "other"
  localparam kind_t KIND_SOF  = 3'd1;
  localparam kind_t KIND_ID   = 3'd2;
  localparam kind_t KIND_DLC  = 3'd3;
  localparam kind_t KIND_DATA = 3'd4;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_TARGET_ID       = 2'd0;
  localparam cfg_idx_t REG_PAYLOAD_MASK    = 2'd1;
  localparam cfg_idx_t REG_PAYLOAD_PATTERN = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

endpackage : cpmm_pkg
`default_nettype wire

### rtl/cpmm_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpmm channel interfaces
// Symbol input, result output and register write channels.
// ---------------------------------------------------------------------------
interface cpmm_sym_if
  import cpmm_pkg::*;
  ();
  logic   valid;
  logic   ready;
  kind_t  symbol_kind;
  value_t symbol_value;
  stamp_t symbol_time;

  modport source (output valid, output symbol_kind, output symbol_value,
                  output symbol_time, input ready);
  modport sink   (input valid, input symbol_kind, input symbol_value,
                  input symbol_time, output ready);
endinterface : cpmm_sym_if

interface cpmm_res_if
  import cpmm_pkg::*;
  ();
  logic   valid;
  logic   ready;
  stamp_t frame_time;
  logic   matched;

  modport source (output valid, output frame_time, output matched, input ready);
  modport sink   (input valid, input frame_time, input matched, output ready);
endinterface : cpmm_res_if

interface cpmm_cfg_if
  import cpmm_pkg::*;
  ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  payload_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : cpmm_cfg_if
`default_nettype wire

### rtl/can_payload_mask_matcher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// can_payload_mask_matcher_core
// A symbol word is taken into the symbol register and moves on through the
// state step into the result register. Throughput: one symbol word per cycle
// while the result register is free or is being emptied. Reset (rst_n
// low, sync) empties both registers, returns to idle and clears the config
// registers.
// ---------------------------------------------------------------------------
module can_payload_mask_matcher_core
  import cpmm_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  cpmm_sym_if.sink   in_sym,
  cpmm_res_if.source out_res,
  cpmm_cfg_if.sink   cfg_wr
);

  // -------------------------------------------------------------------------
  // Configuration registers. Writes land whenever offered; the port never
  // stalls. Unknown indexes are dropped.
  // -------------------------------------------------------------------------
  value_t   target_id_r;
  payload_t payload_mask_r;
  payload_t payload_pattern_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_id_r       <= '0;
      payload_mask_r    <= '0;
      payload_pattern_r <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_TARGET_ID:       target_id_r       <= cfg_wr.data[VALUE_W-1:0];
        REG_PAYLOAD_MASK:    payload_mask_r    <= cfg_wr.data;
        REG_PAYLOAD_PATTERN: payload_pattern_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Symbol register. A held word advances into the state step whenever the
  // result register is free or is being emptied this cycle, so a new word
  // may be taken in the same cycle that the previous one moves on.
  // -------------------------------------------------------------------------
  logic   sym_vld_r;
  kind_t  sym_kind_r;
  value_t sym_value_r;
  stamp_t sym_time_r;

  logic   out_vld_r;
  stamp_t out_time_r;
  logic   out_match_r;

  logic   step_go;
  logic   in_take;

  assign step_go      = sym_vld_r && (!out_vld_r || out_res.ready);
  assign in_sym.ready = !sym_vld_r || step_go;
  assign in_take      = in_sym.valid && in_sym.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_vld_r <= 1'b0;
    end else if (in_take) begin
      sym_vld_r <= 1'b1;
    end else if (step_go) begin
      sym_vld_r <= 1'b0;
    end
  end

  // Payload of the symbol register: no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      sym_kind_r  <= in_sym.symbol_kind;
      sym_value_r <= in_sym.symbol_value;
      sym_time_r  <= in_sym.symbol_time;
    end
  end

  // -------------------------------------------------------------------------
  // Frame tracking state
  // -------------------------------------------------------------------------
  phase_t   phase_r,   phase_nxt;
  payload_t acc_r,     acc_nxt;
  len_t     left_r,    left_nxt;
  stamp_t   stamp_r,   stamp_nxt;

  logic     res_fire;
  logic     res_match;
  payload_t acc_shift;
  len_t     left_dec;

  // Shift the new byte in at the bottom; earlier bytes move towards the top
  assign acc_shift = {acc_r[PAYLOAD_W-BYTE_W-1:0], sym_value_r[BYTE_W-1:0]};
  assign left_dec  = left_r - len_t'(1);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    stamp_nxt = stamp_r;
    res_fire  = 1'b0;
    res_match = ((acc_shift & payload_mask_r) == payload_pattern_r);

    case (phase_r)
      PH_LEN: begin
        // Wait for the length code; ignore anything else but a start of frame
        if (sym_kind_r == KIND_DLC) begin
          left_nxt  = sym_value_r[LEN_W-1:0];
          // Empty frame: back to idle without a result
          phase_nxt = (sym_value_r[LEN_W-1:0] == '0) ? PH_IDLE : PH_DATA;
        end
      end
      PH_DATA: begin
        if (sym_kind_r == KIND_DATA) begin
          acc_nxt  = acc_shift;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            res_fire  = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end else begin
          // Any non-data symbol aborts the frame
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        // Idle (and the unused encoding): look for the target identifier
        phase_nxt = PH_IDLE;
        if (sym_kind_r == KIND_ID && sym_value_r == target_id_r) begin
          stamp_nxt = sym_time_r;
          acc_nxt   = '0;
          phase_nxt = PH_LEN;
        end
      end
    endcase

    // Start of frame always drops back to idle
    if (sym_kind_r == KIND_SOF) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      left_r  <= '0;
    end else if (step_go) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

  // Payload and stamp are always written by an identifier before use
  always_ff @(posedge clk) begin
    if (step_go) begin
      acc_r   <= acc_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Result register. Hold a result until the sink takes it; a step that
  // gives no result simply leaves the register empty.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_go) begin
      out_vld_r <= res_fire;
    end else if (out_res.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && res_fire) begin
      out_time_r  <= stamp_r;
      out_match_r <= res_match;
    end
  end

  assign out_res.valid      = out_vld_r;
  assign out_res.frame_time = out_time_r;
  assign out_res.matched    = out_match_r;

endmodule : can_payload_mask_matcher_core
`default_nettype wire

### rtl/cpmm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpmm_checker
// Port-level checks of the matcher, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cpmm_checker
  import cpmm_pkg::*;
(
  input wire         clk,
  input wire         rst_n,
  input wire         in_valid,
  input wire         in_ready,
  input wire         out_valid,
  input wire         out_ready,
  input wire stamp_t out_frame_time,
  input wire         out_matched
);

  // A stalled result word holds
  `CPMM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CPMM_ASSERT_NXT(a_out_data, out_valid && !out_ready, $stable({out_frame_time, out_matched}))

  // A result appearing on an empty output must trace back to an accepted input word
  `CPMM_ASSERT_IMP(a_out_cause, $rose(out_valid), $past(in_valid && in_ready, 2))

  // Reset leaves no result behind
  `CPMM_ASSERT_IMP(a_out_rst, !$past(rst_n), !out_valid)

endmodule : cpmm_checker

bind can_payload_mask_matcher_core cpmm_checker u_cpmm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_sym.valid),
  .in_ready       (in_sym.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_frame_time (out_res.frame_time),
  .out_matched    (out_res.matched)
);
`default_nettype wire

### tb/can_payload_mask_matcher_core_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// can_payload_mask_matcher_core_checker
// Watches the symbol, result and register channels of the matcher, keeps
// its own frame filter in step with every accepted word and compares each
// accepted result with the oldest outstanding verdict.
// ---------------------------------------------------------------------------
module can_payload_mask_matcher_core_checker
  import cpmm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     sym_valid,
  input  logic     sym_ready,
  input  kind_t    sym_kind,
  input  value_t   sym_value,
  input  stamp_t   sym_time,
  input  logic     res_valid,
  input  logic     res_ready,
  input  stamp_t   res_frame_time,
  input  logic     res_matched,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  payload_t cfg_data,
  output int       fail_count,
  output int       pending_count
);

  typedef struct packed {
    stamp_t frame_time;
    logic   matched;
  } verdict_t;

  value_t   target_id;
  payload_t payload_mask;
  payload_t payload_pattern;
  phase_t   phase;
  payload_t payload_acc;
  len_t     bytes_left;
  stamp_t   start_stamp;
  verdict_t verdicts_due[$];
  verdict_t oldest;
  int       mismatches = 0;

  task automatic filter_symbol(kind_t kind, value_t value, stamp_t stamp);
    verdict_t v;
    case (phase)
      PH_LEN: begin
        if (kind == KIND_DLC) begin
          bytes_left = value[LEN_W-1:0];
          phase      = (bytes_left == '0) ? PH_IDLE : PH_DATA;
        end
      end
      PH_DATA: begin
        if (kind == KIND_DATA) begin
          payload_acc = (payload_acc << BYTE_W) | payload_t'(value[BYTE_W-1:0]);
          bytes_left  = bytes_left - 1'b1;
          if (bytes_left == '0) begin
            v.frame_time = start_stamp;
            v.matched    = ((payload_acc & payload_mask) == payload_pattern);
            verdicts_due = {verdicts_due, v};
            phase = PH_IDLE;
          end
        end else begin
          phase = PH_IDLE;
        end
      end
      default: begin
        phase = PH_IDLE;
        if (kind == KIND_ID && value == target_id) begin
          start_stamp = stamp;
          payload_acc = '0;
          phase       = PH_LEN;
        end
      end
    endcase
    if (kind == KIND_SOF) phase = PH_IDLE;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      target_id       = '0;
      payload_mask    = '0;
      payload_pattern = '0;
      phase           = PH_IDLE;
      payload_acc     = '0;
      bytes_left      = '0;
      start_stamp     = '0;
      verdicts_due.delete();
    end else begin
      // results leave only after their symbol is taken, so compare first
      if (res_valid && res_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result frame_time %h matched %b",
                   $time, res_frame_time, res_matched);
          mismatches++;
        end else begin
          oldest = verdicts_due.pop_front();
          if (res_frame_time !== oldest.frame_time) begin
            $display("%0t: frame_time expected %h got %h",
                     $time, oldest.frame_time, res_frame_time);
            mismatches++;
          end
          if (res_matched !== oldest.matched) begin
            $display("%0t: matched expected %b got %b",
                     $time, oldest.matched, res_matched);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_ID:       target_id       = cfg_data[VALUE_W-1:0];
          REG_PAYLOAD_MASK:    payload_mask    = cfg_data;
          REG_PAYLOAD_PATTERN: payload_pattern = cfg_data;
          default: ;
        endcase
      end
      if (sym_valid && sym_ready) filter_symbol(sym_kind, sym_value, sym_time);
    end
    fail_count    <= mismatches;
    pending_count <= verdicts_due.size();
  end

endmodule : can_payload_mask_matcher_core_checker

### tb/can_payload_mask_matcher_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// can_payload_mask_matcher_core_test
// Drives decoded CAN symbol words into the matcher: a directed run over the
// length-code and framing corner cases, then three random stages of mostly
// well-formed frames under changing filter settings, with back-pressure in the
// first two. The checker beside the block predicts and compares; this
// module gives the verdict.
// ---------------------------------------------------------------------------
module can_payload_mask_matcher_core_test;
  import cpmm_pkg::*;

  // Symbol kind that the block treats as "other"
  localparam kind_t KIND_OTHER = 3'd0;

  // Cycles without any accepted word before the run is abandoned
  localparam int WATCHDOG_LIMIT  = 5000;
  // Result register sits behind the symbol register; allow a margin
  localparam int DRAIN_CYCLES    = 8;
  localparam int ITEMS_PER_STAGE = 430;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cpmm_sym_if sym_ch ();
  cpmm_res_if res_ch ();
  cpmm_cfg_if cfg_ch ();

  int send_idle_pct = 14;
  int take_idle_pct = 50;
  int items_sent    = 0;
  int stalled_cycles = 0;
  int fail_count;
  int pending_count;

  // Copies of the filter registers, used to shape the frames
  value_t   target_id;
  payload_t payload_mask;
  payload_t payload_pattern;

  can_payload_mask_matcher_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_sym  (sym_ch),
    .out_res (res_ch),
    .cfg_wr  (cfg_ch)
  );

  can_payload_mask_matcher_core_checker frame_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sym_valid      (sym_ch.valid),
    .sym_ready      (sym_ch.ready),
    .sym_kind       (sym_ch.symbol_kind),
    .sym_value      (sym_ch.symbol_value),
    .sym_time       (sym_ch.symbol_time),
    .res_valid      (res_ch.valid),
    .res_ready      (res_ch.ready),
    .res_frame_time (res_ch.frame_time),
    .res_matched    (res_ch.matched),
    .cfg_valid      (cfg_ch.valid),
    .cfg_ready      (cfg_ch.ready),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: drop ready at random in the chosen share of cycles
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // Watchdog: any accepted word on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (sym_ch.valid && sym_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("can_payload_mask_matcher_core: mismatch");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  function automatic value_t random_value();
    return value_t'($urandom);
  endfunction

  function automatic payload_t random_payload();
    return {$urandom, $urandom};
  endfunction

  function automatic stamp_t random_stamp();
    return stamp_t'(random_payload());
  endfunction

  // Present one symbol word and hold it until taken. Valid stays high after
  // the handshake so that back-to-back words never toggle it within a step.
  task automatic send_symbol(kind_t kind, value_t value, stamp_t stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      sym_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sym_ch.valid        <= 1'b1;
    sym_ch.symbol_kind  <= kind;
    sym_ch.symbol_value <= value;
    sym_ch.symbol_time  <= stamp;
    @(posedge clk);
    while (!sym_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, payload_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Load all three filter registers; junk above the identifier width must
  // be dropped by the block.
  task automatic set_filter(value_t id, payload_t mask, payload_t pattern);
    payload_t id_word;
    id_word              = random_payload();
    id_word[VALUE_W-1:0] = id;
    write_reg(REG_TARGET_ID, id_word);
    write_reg(REG_PAYLOAD_MASK, mask);
    write_reg(REG_PAYLOAD_PATTERN, pattern);
    target_id       = id;
    payload_mask    = mask;
    payload_pattern = pattern;
  endtask

  // Lower valid and wait until every verdict is in and the pipe is empty
  task automatic settle();
    sym_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One frame: optional start of frame, identifier, optional other symbol,
  // length code, data words. The last eight data bytes carry body, most
  // significant byte first. A broken frame may be cut short by a non-data symbol.
  task automatic send_frame(value_t id, value_t len_word, payload_t body, bit broken);
    int     n_bytes;
    int     cut_at;
    int     k;
    value_t word;
    kind_t  cut_kind;
    n_bytes = int'(len_word[LEN_W-1:0]);
    cut_at  = broken ? $urandom_range(n_bytes) : n_bytes + 1;
    if ($urandom_range(4) != 0) send_symbol(KIND_SOF, random_value(), random_stamp());
    send_symbol(KIND_ID, id, random_stamp());
    if ($urandom_range(9) == 0) send_symbol(KIND_OTHER, random_value(), random_stamp());
    send_symbol(KIND_DLC, len_word, random_stamp());
    for (int i = 0; i < n_bytes; i++) begin
      if (i == cut_at) begin
        cut_kind = kind_t'($urandom_range(7));
        if (cut_kind == KIND_DATA) cut_kind = KIND_SOF;
        send_symbol(cut_kind, random_value(), random_stamp());
        break;
      end
      k    = n_bytes - 1 - i;
      word = (k < 8) ? value_t'(body[8*k +: 8]) : random_value() & value_t'(8'hFF);
      // upper bits of a data word must be ignored
      if ($urandom_range(7) == 0) word = word | (random_value() << BYTE_W);
      send_symbol(KIND_DATA, word, random_stamp());
    end
  endtask

  // Mostly well-formed frames with random content, the rest loose symbols
  task automatic random_traffic(int count);
    int       stop_at;
    int       pick;
    value_t   id;
    value_t   len_word;
    payload_t body;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        id = ($urandom_range(99) < 85) ? target_id : random_value();
        pick = $urandom_range(99);
        if (pick < 50)      len_word = value_t'(8);
        else if (pick < 80) len_word = value_t'($urandom_range(7, 1));
        else if (pick < 95) len_word = value_t'($urandom_range(15, 9));
        else                len_word = value_t'(16 * $urandom_range(1));
        // length codes above fifteen keep only their low bits
        if ($urandom_range(9) == 0) len_word = len_word | (random_value() << LEN_W);
        // hold the masked bits to the pattern in most frames so that
        // matches are common
        body = random_payload();
        if ($urandom_range(9) < 6) body = payload_pattern | (body & ~payload_mask);
        send_frame(id, len_word, body, ($urandom_range(9) == 0));
      end else begin
        send_symbol(kind_t'($urandom_range(7)), random_value(), random_stamp());
      end
    end
  endtask

  initial begin
    sym_ch.valid        <= 1'b0;
    sym_ch.symbol_kind  <= '0;
    sym_ch.symbol_value <= '0;
    sym_ch.symbol_time  <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= '0;
    cfg_ch.data         <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: widest identifier, full mask, fixed pattern
    set_filter('1, '1, 64'h0123_4567_89AB_CDEF);
    // loose symbol with every bit set, then a start of frame in idle
    send_symbol(kind_t'(7), '1, '1);
    send_symbol(KIND_SOF, '0, '0);
    // zero length code: back to idle with no result
    send_symbol(KIND_ID, target_id, '1);
    send_symbol(KIND_DLC, '0, random_stamp());
    // length code sixteen wraps to zero
    send_symbol(KIND_ID, target_id, random_stamp());
    send_symbol(KIND_DLC, value_t'(16), random_stamp());
    // other symbol while waiting for the length is ignored; wide length
    // code and wide data word keep only their low bits
    send_symbol(KIND_ID, target_id, '0);
    send_symbol(KIND_OTHER, '1, random_stamp());
    send_symbol(KIND_DLC, value_t'(29'h1FFF_FFF1), random_stamp());
    send_symbol(KIND_DATA, value_t'(29'h1FFF_FFAB), '1);
    // non-data symbol while collecting abandons the frame
    send_symbol(KIND_ID, target_id, random_stamp());
    send_symbol(KIND_DLC, value_t'(3), random_stamp());
    send_symbol(KIND_DATA, value_t'(8'h5A), random_stamp());
    send_symbol(KIND_ID, target_id, random_stamp());
    send_symbol(KIND_DATA, value_t'(8'hFF), random_stamp());
    // start of frame right after the identifier
    send_symbol(KIND_ID, target_id, random_stamp());
    send_symbol(KIND_SOF, random_value(), random_stamp());
    send_symbol(KIND_DATA, value_t'(8'h00), random_stamp());
    // nine bytes: the first shifts out and the rest equal the pattern
    send_frame(target_id, value_t'(9), payload_pattern, 1'b0);
    settle();

    // Random stage one: sender rarely idles, receiver often stalls
    set_filter(random_value(), random_payload(), '0);
    set_filter(target_id, payload_mask, random_payload() & payload_mask);
    random_traffic(ITEMS_PER_STAGE);
    settle();

    // Stage two: roles swapped, all-zero filter so that every frame matches
    send_idle_pct = 50;
    take_idle_pct = 14;
    set_filter('0, '0, '0);
    random_traffic(ITEMS_PER_STAGE);
    settle();

    // Stage three: no idling, full mask against a random pattern
    send_idle_pct = 0;
    take_idle_pct = 0;
    set_filter(random_value(), '1, random_payload());
    random_traffic(ITEMS_PER_STAGE);
    settle();

    if (fail_count == 0) begin
      $display("can_payload_mask_matcher_core: match");
    end else begin
      $display("can_payload_mask_matcher_core: mismatch");
    end
    $finish;
  end

endmodule : can_payload_mask_matcher_core_test

### filelist.f
+incdir+rtl
rtl/cpmm_pkg.sv
rtl/cpmm_ifs.sv
rtl/can_payload_mask_matcher_core.sv
rtl/cpmm_checker.sv
tb/can_payload_mask_matcher_core_checker.sv
tb/can_payload_mask_matcher_core_test.sv
